// ===== design/pps_pkg.sv =====
// Types, codes and constants shared by the pump plant sequencer.
// No dependencies; every other design file except pps_chan_if refers to this package by scoped name.
`timescale 1ns / 1ps

package pps_pkg;

  localparam int CFG_W   = 24;
  localparam int RETRY_W = 4;
  localparam int ID_W    = 16;
  localparam int IDX_W   = 3;

  localparam logic [CFG_W-1:0]   PERSIST_RST     = 24'd2000;
  localparam logic [CFG_W-1:0]   LOW_FILL_RST    = 24'd5000;
  localparam logic [CFG_W-1:0]   PCHECK_RST      = 24'd15000;
  localparam logic [CFG_W-1:0]   FLUSH_RST       = 24'd30000;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd3;
  localparam logic [RETRY_W-1:0] RETRY_SAT       = 4'd15;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_STARTING  = 3'd1,
    ST_PRODUCING = 3'd2,
    ST_FLUSHING  = 3'd3,
    ST_STOPPING  = 3'd4,
    ST_FAULT     = 3'd5
  } state_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_PERSIST     = 3'd0,
    CFG_LOW_FILL    = 3'd1,
    CFG_PCHECK      = 3'd2,
    CFG_FLUSH       = 3'd3,
    CFG_RETRY_LIMIT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic             demand;
    logic             raw_water;
    logic             pressure_good;
    logic             cmd_valid;
    logic             cmd_expired;
    logic [1:0]       operation;
    logic [ID_W-1:0]  cmd_id;
  } in_item_t;

  typedef struct packed {
    logic               pump_low;
    logic               pump_high;
    logic               valve_flush;
    logic               valve_inlet;
    logic [2:0]         plant_state;
    logic [RETRY_W-1:0] retries;
    logic               running;
    logic               ack_valid;
    logic               ack_rejected;
    logic [ID_W-1:0]    ack_id;
    logic [1:0]         ack_operation;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] wdata;
  } cfg_req_t;

  // timing and retry limits handed to the sequencer
  typedef struct packed {
    logic [CFG_W-1:0]   low_fill_ms;
    logic [CFG_W-1:0]   pressure_check_ms;
    logic [CFG_W-1:0]   flush_ms;
    logic [RETRY_W-1:0] retry_limit;
  } seq_cfg_t;

  // qualified sensor flags
  typedef struct packed {
    logic dem_ok;
    logic raw_ok;
    logic prs_ok;
  } qual_t;

  typedef struct packed {
    logic low;
    logic high;
    logic flush;
    logic inlet;
  } drv_t;

endpackage

// ===== design/pps_chan_if.sv =====
// Valid/ready channel carrying one payload of a chosen type.
// Depends on nothing; payload types come from pps_pkg at instantiation.
`timescale 1ns / 1ps

interface pps_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/pps_qual.sv =====
// Run counters that qualify the demand, raw water and pressure flags.
// Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_qual #(
  parameter int TIMER_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     demand,
  input  logic                     raw_water,
  input  logic                     pressure_good,
  input  logic [pps_pkg::CFG_W-1:0] persist_ms,
  output pps_pkg::qual_t           ok
);

  localparam int CMP_W = (TIMER_BITS > pps_pkg::CFG_W) ? TIMER_BITS : pps_pkg::CFG_W;
  localparam logic [TIMER_BITS-1:0] RUN_MAX = {TIMER_BITS{1'b1}};

  logic [TIMER_BITS-1:0] run_r   [3];
  logic [TIMER_BITS-1:0] run_nxt [3];
  logic [2:0]            flag;
  logic [2:0]            good;

  assign flag = {demand, raw_water, pressure_good};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!flag[i]) begin
        run_nxt[i] = '0;
      end else if (run_r[i] == RUN_MAX) begin
        run_nxt[i] = RUN_MAX;
      end else begin
        run_nxt[i] = run_r[i] + 1'b1;
      end
      // good once the run, less its first tick, exceeds the persistence time
      good[i] = (run_nxt[i] != '0) &&
                ((CMP_W'(run_nxt[i]) - CMP_W'(1)) > CMP_W'(persist_ms));
    end
  end

  assign ok.dem_ok = good[2];
  assign ok.raw_ok = good[1];
  assign ok.prs_ok = good[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) run_r[i] <= '0;
    end else if (adv) begin
      for (int i = 0; i < 3; i++) run_r[i] <= run_nxt[i];
    end
  end

endmodule

// ===== design/pps_fsm.sv =====
// Plant sequencer: command handling, state machine, state timer, retry count, drives.
// Depends on pps_pkg and on the qualified flags from pps_qual.
`timescale 1ns / 1ps

module pps_fsm #(
  parameter int TIMER_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  pps_pkg::in_item_t   item,
  input  pps_pkg::qual_t      ok,
  input  pps_pkg::seq_cfg_t   cfg,
  output pps_pkg::out_item_t  res
);

  localparam int CMP_W = (TIMER_BITS > pps_pkg::CFG_W) ? TIMER_BITS : pps_pkg::CFG_W;
  localparam logic [TIMER_BITS-1:0] TIS_MAX = {TIMER_BITS{1'b1}};

  pps_pkg::state_t                 state_r, state_nxt, s_cmd;
  logic [pps_pkg::RETRY_W-1:0]     retry_r, retry_nxt, rt_cmd;
  logic [TIMER_BITS-1:0]           tis_r, tis_nxt, tis_cmd, tis_inc;
  pps_pkg::drv_t                   drv_r, drv_nxt;
  logic                            ack, rej, allowed;
  logic                            run_st;
  pps_pkg::op_t                    op;
  logic                            gt_low, gt_pchk, gt_flush;

  assign op      = pps_pkg::op_t'(item.operation);
  assign tis_inc = (tis_r == TIS_MAX) ? TIS_MAX : tis_r + 1'b1;
  assign run_st  = (state_r == pps_pkg::ST_STARTING) ||
                   (state_r == pps_pkg::ST_PRODUCING) ||
                   (state_r == pps_pkg::ST_FLUSHING);

  // remote command, applied ahead of the sequencing step
  always_comb begin
    s_cmd   = state_r;
    rt_cmd  = retry_r;
    tis_cmd = tis_inc;
    ack     = item.cmd_valid && !item.cmd_expired;
    case (op)
      pps_pkg::OP_START: allowed = (state_r == pps_pkg::ST_IDLE);
      pps_pkg::OP_STOP:  allowed = run_st;
      pps_pkg::OP_FLUSH: allowed = (state_r == pps_pkg::ST_PRODUCING);
      pps_pkg::OP_RESET: allowed = (state_r == pps_pkg::ST_FAULT) ||
                                   (state_r == pps_pkg::ST_STARTING) ||
                                   (state_r == pps_pkg::ST_FLUSHING);
      default:           allowed = 1'b0;
    endcase
    rej = ack && !allowed;
    if (ack && allowed) begin
      case (op)
        pps_pkg::OP_START: begin
          s_cmd   = pps_pkg::ST_STARTING;
          tis_cmd = '0;
        end
        pps_pkg::OP_STOP: begin
          s_cmd   = (state_r == pps_pkg::ST_PRODUCING) ? pps_pkg::ST_FLUSHING
                                                       : pps_pkg::ST_IDLE;
          tis_cmd = '0;
        end
        pps_pkg::OP_FLUSH: begin
          s_cmd   = pps_pkg::ST_FLUSHING;
          tis_cmd = '0;
        end
        default: begin
          rt_cmd = '0;
          s_cmd  = pps_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign gt_low   = CMP_W'(tis_cmd) > CMP_W'(cfg.low_fill_ms);
  assign gt_pchk  = CMP_W'(tis_cmd) > CMP_W'(cfg.pressure_check_ms);
  assign gt_flush = CMP_W'(tis_cmd) > CMP_W'(cfg.flush_ms);

  // next state
  always_comb begin
    state_nxt = s_cmd;
    retry_nxt = rt_cmd;
    tis_nxt   = tis_cmd;
    case (s_cmd)
      pps_pkg::ST_IDLE: begin
        if (ok.dem_ok && ok.raw_ok) begin
          state_nxt = pps_pkg::ST_STARTING;
          tis_nxt   = '0;
        end
      end
      pps_pkg::ST_STARTING: begin
        if (!ok.raw_ok) begin
          state_nxt = pps_pkg::ST_IDLE;
        end else if (gt_pchk) begin
          if (ok.prs_ok) begin
            retry_nxt = '0;
            state_nxt = pps_pkg::ST_PRODUCING;
          end else begin
            if (rt_cmd != pps_pkg::RETRY_SAT) retry_nxt = rt_cmd + 1'b1;
            state_nxt = pps_pkg::ST_IDLE;
          end
        end
      end
      pps_pkg::ST_PRODUCING: begin
        if (!ok.dem_ok) begin
          state_nxt = pps_pkg::ST_FLUSHING;
          tis_nxt   = '0;
        end
        if (!ok.raw_ok || !ok.prs_ok) state_nxt = pps_pkg::ST_IDLE;
      end
      pps_pkg::ST_FLUSHING: begin
        if (gt_flush) state_nxt = pps_pkg::ST_IDLE;
      end
      pps_pkg::ST_FAULT: begin
        state_nxt = pps_pkg::ST_FAULT;
      end
      default: begin
        state_nxt = pps_pkg::ST_IDLE;
      end
    endcase
    if (retry_nxt >= cfg.retry_limit) state_nxt = pps_pkg::ST_FAULT;
  end

  // drives follow the state handled in this tick; stopping keeps the old ones
  always_comb begin
    case (s_cmd)
      pps_pkg::ST_IDLE:      drv_nxt = '{low: 1'b0, high: 1'b0, flush: 1'b0, inlet: 1'b0};
      pps_pkg::ST_STARTING:  drv_nxt = '{low: 1'b1, high: ok.raw_ok && gt_low,
                                        flush: 1'b0, inlet: 1'b1};
      pps_pkg::ST_PRODUCING: drv_nxt = '{low: 1'b1, high: 1'b1, flush: 1'b0, inlet: 1'b1};
      pps_pkg::ST_FLUSHING:  drv_nxt = '{low: 1'b1, high: 1'b0, flush: 1'b1, inlet: 1'b1};
      pps_pkg::ST_FAULT:     drv_nxt = '{low: 1'b0, high: 1'b0, flush: 1'b0, inlet: 1'b0};
      default:               drv_nxt = drv_r;
    endcase
  end

  always_comb begin
    res.pump_low      = drv_nxt.low;
    res.pump_high     = drv_nxt.high;
    res.valve_flush   = drv_nxt.flush;
    res.valve_inlet   = drv_nxt.inlet;
    res.plant_state   = state_nxt;
    res.retries       = retry_nxt;
    res.running       = (state_nxt == pps_pkg::ST_STARTING) ||
                        (state_nxt == pps_pkg::ST_PRODUCING) ||
                        (state_nxt == pps_pkg::ST_FLUSHING);
    res.ack_valid     = ack;
    res.ack_rejected  = rej;
    res.ack_id        = ack ? item.cmd_id : '0;
    res.ack_operation = ack ? item.operation : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pps_pkg::ST_IDLE;
      retry_r <= '0;
      tis_r   <= '0;
      drv_r   <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
      retry_r <= retry_nxt;
      tis_r   <= tis_nxt;
      drv_r   <= drv_nxt;
    end
  end

endmodule

// ===== design/pump_plant_sequencer_top.sv =====
// Pump plant sequencer: an accepted request is held in the input register, then one
// pass of sequencing logic writes the result register and the state update.
// Throughput one request per cycle while out_ch is not stalled.
// Synchronous active-low reset: plant idle, counters zero, drives off,
// configuration back to its defaults. Configuration writes are taken every cycle.
`timescale 1ns / 1ps

module pump_plant_sequencer_top #(
  parameter int TIMER_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  pps_chan_if.sink   in_ch,
  pps_chan_if.source out_ch,
  pps_chan_if.sink   cfg_ch
);

  logic                        in_valid_r, out_valid_r, adv;
  pps_pkg::in_item_t           in_data_r;
  pps_pkg::out_item_t          out_data_r, res;
  pps_pkg::qual_t              ok;
  pps_pkg::seq_cfg_t           seq_cfg;
  pps_pkg::cfg_req_t           cfg_req;
  logic [pps_pkg::CFG_W-1:0]   persist_r, low_fill_r, pcheck_r, flush_r;
  logic [pps_pkg::RETRY_W-1:0] retry_limit_r;

  assign cfg_req      = cfg_ch.data;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      persist_r     <= pps_pkg::PERSIST_RST;
      low_fill_r    <= pps_pkg::LOW_FILL_RST;
      pcheck_r      <= pps_pkg::PCHECK_RST;
      flush_r       <= pps_pkg::FLUSH_RST;
      retry_limit_r <= pps_pkg::RETRY_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      case (pps_pkg::cfg_idx_t'(cfg_req.idx))
        pps_pkg::CFG_PERSIST:     persist_r     <= cfg_req.wdata;
        pps_pkg::CFG_LOW_FILL:    low_fill_r    <= cfg_req.wdata;
        pps_pkg::CFG_PCHECK:      pcheck_r      <= cfg_req.wdata;
        pps_pkg::CFG_FLUSH:       flush_r       <= cfg_req.wdata;
        pps_pkg::CFG_RETRY_LIMIT: retry_limit_r <= cfg_req.wdata[pps_pkg::RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  assign seq_cfg.low_fill_ms       = low_fill_r;
  assign seq_cfg.pressure_check_ms = pcheck_r;
  assign seq_cfg.flush_ms          = flush_r;
  assign seq_cfg.retry_limit       = retry_limit_r;

  // the held request moves on when the result register is free or being drained
  assign adv         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) in_data_r <= in_ch.data;
  end

  pps_qual #(.TIMER_BITS(TIMER_BITS)) u_qual (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .demand        (in_data_r.demand),
    .raw_water     (in_data_r.raw_water),
    .pressure_good (in_data_r.pressure_good),
    .persist_ms    (persist_r),
    .ok            (ok)
  );

  pps_fsm #(.TIMER_BITS(TIMER_BITS)) u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (in_data_r),
    .ok    (ok),
    .cfg   (seq_cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= res;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // a stalled request stays put in the input register
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(in_data_r))
    else $error("input register lost a stalled request");

  // no ack means the echoed command fields are cleared
  a_ack_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.ack_valid |->
      !out_data_r.ack_rejected && out_data_r.ack_id == '0 &&
      out_data_r.ack_operation == 2'd0)
    else $error("ack fields set without an ack");

  a_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.running ==
      (out_data_r.plant_state == pps_pkg::ST_STARTING ||
       out_data_r.plant_state == pps_pkg::ST_PRODUCING ||
       out_data_r.plant_state == pps_pkg::ST_FLUSHING))
    else $error("running flag disagrees with plant state");

  // a result is only produced from a held request
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && !in_valid_r |=> !out_valid_r)
    else $error("result appeared with no request");

endmodule
